@@ rtl/core/lcps_pkg.sv @@
// ----------------------------------------------------------------------------
// lcps_pkg: shared types and constants for the least-connections selector
// Field widths, command and register codes, and the structs that travel
// between the control block and the row of server cells.
// ----------------------------------------------------------------------------
package lcps_pkg;

  localparam int SRV_W           = 4;   // server index field
  localparam int SRV_CNT_W       = 5;   // counts of servers, 0..31
  localparam int FAIL_W          = 8;   // successive-failure counter
  localparam int CONN_OUT_W      = 16;  // reported connection count
  localparam int INDEX_SPACE     = 16;  // entries reachable by the index field
  localparam int DEF_MAX_SERVERS = 16;
  localparam int DEF_CONN_WIDTH  = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [FAIL_W-1:0]    FAIL_MAX        = '1;
  localparam logic [SRV_CNT_W-1:0] RST_SERVERS     = 5'd16;
  localparam logic [FAIL_W-1:0]    RST_FAIL_LIMIT  = 8'd3;

  // event kinds
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT  = 1'b1;

  // update command broadcast to every cell
  typedef struct packed {
    logic upd;
    logic cmd;
    logic success;
  } lcps_upd_t;

  // partial scan result handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [SRV_W-1:0]     best;
    logic [SRV_CNT_W-1:0] excluded;
    logic                 alarm;
  } lcps_scan_t;

endpackage

@@ rtl/core/lcps_cell.sv @@
// ----------------------------------------------------------------------------
// lcps_cell: one server entry of the selector row
// Holds the open-connection and failure counts of one server, applies the
// broadcast update when addressed, and folds its entry into the scan token
// passing through on its way to the next cell.
// ----------------------------------------------------------------------------
module lcps_cell
  import lcps_pkg::*;
#(
  parameter int CONN_WIDTH = DEF_CONN_WIDTH,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcps_upd_t             upd,
  input  logic                  hit,
  input  logic                  enabled,
  input  logic [FAIL_W-1:0]     failure_limit,
  input  lcps_scan_t            scan_i,
  input  logic [CONN_WIDTH-1:0] conn_i,
  output lcps_scan_t            scan_o,
  output logic [CONN_WIDTH-1:0] conn_o
);

  localparam logic [CONN_WIDTH-1:0] CONN_MAX = '1;
  localparam logic [SRV_W-1:0]      MY_IDX   = SRV_W'(CELL_IDX);

  logic [CONN_WIDTH-1:0] conn_r, conn_nxt;
  logic [FAIL_W-1:0]     fail_r, fail_nxt;
  logic                  alarm_r, alarm_nxt;
  lcps_scan_t            scan_r, scan_nxt;
  logic [CONN_WIDTH-1:0] sconn_r, sconn_nxt;
  logic [FAIL_W-1:0]     fail_inc;

  assign fail_inc = fail_r + 1'b1;

  always_comb begin
    conn_nxt  = conn_r;
    fail_nxt  = fail_r;
    alarm_nxt = alarm_r;
    if (upd.upd) begin
      alarm_nxt = 1'b0;
      if (hit && enabled) begin
        unique case (upd.cmd)
          CMD_START: begin
            if (conn_r != CONN_MAX) conn_nxt = conn_r + 1'b1;
          end
          CMD_FINISH: begin
            if (conn_r != '0) conn_nxt = conn_r - 1'b1;
            if (upd.success) begin
              fail_nxt = '0;
            end else if (fail_r != FAIL_MAX) begin
              fail_nxt  = fail_inc;
              alarm_nxt = (fail_inc == failure_limit);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // fold this entry into the passing token
  always_comb begin
    scan_nxt  = scan_i;
    sconn_nxt = conn_i;
    if (scan_i.valid) begin
      scan_nxt.alarm = scan_i.alarm | alarm_r;
      if (enabled) begin
        if (fail_r >= failure_limit) begin
          scan_nxt.excluded = scan_i.excluded + 1'b1;
        end else if (!scan_i.found || (conn_r < conn_i)) begin
          scan_nxt.found = 1'b1;
          scan_nxt.best  = MY_IDX;
          sconn_nxt      = conn_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r       <= '0;
      fail_r       <= '0;
      alarm_r      <= 1'b0;
      scan_r.valid <= 1'b0;
    end else begin
      conn_r       <= conn_nxt;
      fail_r       <= fail_nxt;
      alarm_r      <= alarm_nxt;
      scan_r.valid <= scan_nxt.valid;
    end
    scan_r.found    <= scan_nxt.found;
    scan_r.best     <= scan_nxt.best;
    scan_r.excluded <= scan_nxt.excluded;
    scan_r.alarm    <= scan_nxt.alarm;
    sconn_r         <= sconn_nxt;
  end

  assign scan_o = scan_r;
  assign conn_o = sconn_r;

endmodule

@@ rtl/core/least_connections_proxy_selector.sv @@
// ----------------------------------------------------------------------------
// least_connections_proxy_selector: least-connections server choice
// Input transactions carry one event (request started or finished) for one
// server. in_tuser is the event kind, in_tdata the server index and the
// success flag. After the event is applied, a scan token walks a row of
// MAX_SERVERS cells, one cell per cycle, and collects the usable server with
// the fewest open connections (lowest index on ties), the excluded count and
// the failure alarm. Each event yields exactly one result transaction.
// One event is worked on at a time: no new event is taken until the result
// of the last one has left the cell row. A finished result sits in the
// output register and the next event is taken meanwhile; if the receiver
// stalls, a second result is held until the output register frees, and no
// input is taken while it waits. Configuration (servers_in_use,
// failure_limit) is written on the cfg channel, which is always ready; the
// user must write it only while the block is idle, which the block itself
// does not enforce.
// Reset clears all counts, sets servers_in_use to 16 and failure_limit to 3.
// ----------------------------------------------------------------------------
module least_connections_proxy_selector
  import lcps_pkg::*;
#(
  parameter int MAX_SERVERS = DEF_MAX_SERVERS,
  parameter int CONN_WIDTH  = DEF_CONN_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] server_index, [4] success
  input  logic                   in_tuser,   // [0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] best_server,
                                             // [19:4] best_connections,
                                             // [20] none_usable,
                                             // [21] over_half_failed,
                                             // [22] failure_alarm
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LIM = (MAX_SERVERS < INDEX_SPACE) ? MAX_SERVERS : INDEX_SPACE;
  localparam logic [SRV_CNT_W-1:0] ENTRY_LIM = SRV_CNT_W'(LIM);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LAUNCH,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    cmd_r, cmd_nxt;
  logic [SRV_W-1:0]        idx_r, idx_nxt;
  logic                    succ_r, succ_nxt;
  logic [SRV_CNT_W-1:0]    servers_r;
  logic [FAIL_W-1:0]       fail_limit_r;
  logic [OUT_TDATA_W-1:0]  hold_r, hold_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic [SRV_CNT_W-1:0]    entries;
  logic                    in_fire;
  logic                    out_free;
  lcps_upd_t               upd;
  lcps_scan_t              scan_w [MAX_SERVERS+1];
  logic [CONN_WIDTH-1:0]   conn_w [MAX_SERVERS+1];
  logic [MAX_SERVERS-1:0]  tok_v;
  lcps_scan_t              tail;
  logic [CONN_OUT_W-1:0]   best_conn;
  logic                    over_half;
  logic [OUT_TDATA_W-1:0]  result;

  assign entries   = (servers_r > ENTRY_LIM) ? ENTRY_LIM : servers_r;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign upd.upd     = (state_r == ST_UPDATE);
  assign upd.cmd     = cmd_r;
  assign upd.success = succ_r;

  // inject a fresh token at the head of the row
  assign scan_w[0] = '{valid: (state_r == ST_LAUNCH), found: 1'b0, best: '0,
                       excluded: '0, alarm: 1'b0};
  assign conn_w[0] = '0;

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    logic hit;
    logic enabled;
    if (i < INDEX_SPACE) begin : g_addr
      assign hit     = (idx_r == SRV_W'(i));
      assign enabled = (SRV_CNT_W'(i) < entries);
    end else begin : g_spare
      assign hit     = 1'b0;
      assign enabled = 1'b0;
    end
    lcps_cell #(
      .CONN_WIDTH (CONN_WIDTH),
      .CELL_IDX   (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .upd           (upd),
      .hit           (hit),
      .enabled       (enabled),
      .failure_limit (fail_limit_r),
      .scan_i        (scan_w[i]),
      .conn_i        (conn_w[i]),
      .scan_o        (scan_w[i+1]),
      .conn_o        (conn_w[i+1])
    );
    assign tok_v[i] = scan_w[i+1].valid;
  end

  assign tail = scan_w[MAX_SERVERS];

  if (CONN_WIDTH > CONN_OUT_W) begin : g_sat
    assign best_conn = (|conn_w[MAX_SERVERS][CONN_WIDTH-1:CONN_OUT_W]) ?
                       '1 : conn_w[MAX_SERVERS][CONN_OUT_W-1:0];
  end else begin : g_ext
    assign best_conn = CONN_OUT_W'(conn_w[MAX_SERVERS]);
  end

  assign over_half = (tail.excluded > (entries >> 1));
  assign result    = {1'b0, tail.alarm, over_half, !tail.found, best_conn, tail.best};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    succ_nxt      = succ_r;
    hold_nxt      = hold_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_tuser;
          idx_nxt   = in_tdata[SRV_W-1:0];
          succ_nxt  = in_tdata[SRV_W];
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_LAUNCH;
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (tail.valid) begin
          if (out_free) begin
            out_data_nxt  = result;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            hold_nxt  = result;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_data_nxt  = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    succ_r     <= succ_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servers_r    <= RST_SERVERS;
      fail_limit_r <= RST_FAIL_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SERVERS_IN_USE: servers_r    <= cfg_data[SRV_CNT_W-1:0];
        CFG_FAILURE_LIMIT:  fail_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // only one token may be in flight along the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_v))
    else $error("more than one scan token in the cell row");

  // a token leaves the row only while a scan is under way
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == ST_SCAN))
    else $error("scan token emerged outside a scan");

  // an accepted event is applied on the following cycle
  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_UPDATE) && upd.upd)
    else $error("accepted event not applied");

  // a chosen server implies at least one entry was not excluded
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && tail.found) |-> (tail.excluded < entries))
    else $error("server chosen although every entry is excluded");

  // a result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (state_r != ST_IDLE) || $past(state_r == ST_IDLE)
      || out_valid_r)
    else $error("pending result dropped");
`endif

endmodule

@@ dv/tb_least_connections_proxy_selector.sv @@
// ----------------------------------------------------------------------------
// tb_least_connections_proxy_selector: self-checking bench for the selector
// Drives start and finish events over the input stream and predicts each
// selection report from a local copy of the server table. It walks through
// several table sizes and failure limits, including the out-of-range ones,
// and applies random stalls on both streams with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_least_connections_proxy_selector;
  import lcps_pkg::*;

  localparam int SETTLE_CYCLES  = DEF_MAX_SERVERS + 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic             cmd;
    logic [SRV_W-1:0] srv;
    logic             ok;
  } srv_event_t;

  typedef struct packed {
    logic [SRV_W-1:0]      best;
    logic [CONN_OUT_W-1:0] conns;
    logic                  none_usable;
    logic                  over_half;
    logic                  alarm;
  } pick_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // local copy of the server table and its registers
  logic [DEF_CONN_WIDTH-1:0] conn_cnt [DEF_MAX_SERVERS];
  logic [FAIL_W-1:0]         fail_run [DEF_MAX_SERVERS];
  logic [SRV_CNT_W-1:0]      cfg_servers;
  logic [FAIL_W-1:0]         cfg_fail_limit;

  srv_event_t pending_events[$];
  pick_t      predicted_picks[$];

  logic in_offer  = 1'b0;
  logic steady    = 1'b0;
  logic hold_req  = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   err_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  least_connections_proxy_selector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [3:0] server_index, [4] success
    .in_tuser   (in_tuser),   // [0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [3:0] best_server, [19:4] best_connections,
                              // [20] none_usable, [21] over_half_failed,
                              // [22] failure_alarm
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int unsigned live_entries();
    int unsigned n;
    n = cfg_servers;
    if (n > DEF_MAX_SERVERS) n = DEF_MAX_SERVERS;
    if (n > INDEX_SPACE) n = INDEX_SPACE;
    return n;
  endfunction

  // Apply one event to the table, then pick the least-loaded usable server.
  function automatic pick_t apply_event(logic cmd, logic [SRV_W-1:0] srv, logic ok);
    pick_t       r;
    int unsigned n;
    int unsigned excl;
    logic        found;
    r     = '0;
    n     = live_entries();
    excl  = 0;
    found = 1'b0;
    if (srv < n) begin
      if (cmd == CMD_START) begin
        if (conn_cnt[srv] != '1) conn_cnt[srv] = conn_cnt[srv] + 1'b1;
      end else begin
        if (conn_cnt[srv] != '0) conn_cnt[srv] = conn_cnt[srv] - 1'b1;
        if (ok) begin
          fail_run[srv] = '0;
        end else if (fail_run[srv] != FAIL_MAX) begin
          fail_run[srv] = fail_run[srv] + 1'b1;
          if (fail_run[srv] == cfg_fail_limit) r.alarm = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (fail_run[i] >= cfg_fail_limit) begin
        excl++;
      end else if (!found || conn_cnt[i] < r.conns) begin
        found   = 1'b1;
        r.best  = SRV_W'(i);
        r.conns = conn_cnt[i];
      end
    end
    r.none_usable = !found;
    r.over_half   = excl > n / 2;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void add_event(logic cmd, int unsigned srv, logic ok);
    srv_event_t ev;
    ev.cmd = cmd;
    ev.srv = SRV_W'(srv);
    ev.ok  = ok;
    pending_events.push_back(ev);
  endfunction

  // Mostly in-range events with random content, a tenth aimed anywhere.
  function automatic void queue_traffic(int count, int fail_pct);
    int unsigned n;
    int unsigned srv;
    n = live_entries();
    for (int k = 0; k < count; k++) begin
      if (n != 0 && $urandom_range(99) < 90) srv = $urandom_range(n - 1);
      else srv = $urandom_range(INDEX_SPACE - 1);
      add_event(($urandom_range(99) < 55) ? CMD_START : CMD_FINISH, srv,
                $urandom_range(99) >= fail_pct);
    end
  endfunction

  // Called at a falling edge; leaves valid high so back-to-back writes chain.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SERVERS_IN_USE) cfg_servers = val[SRV_CNT_W-1:0];
    else cfg_fail_limit = val;
    @(negedge clk);
  endtask

  task automatic reconfigure(int unsigned servers, int unsigned limit);
    write_reg(CFG_SERVERS_IN_USE, CFG_DATA_W'(servers));
    write_reg(CFG_FAILURE_LIMIT, CFG_DATA_W'(limit));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_events();
    while (pending_events.size() != 0 || predicted_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender: hold an offered transaction until it is taken
  always @(negedge clk) begin
    if (rst_n && !in_offer && pending_events.size() != 0 &&
        (steady || $urandom_range(99) >= 7)) begin
      in_tvalid <= 1'b1;
      in_tuser  <= pending_events[0].cmd;
      in_tdata  <= {3'b000, pending_events[0].ok, pending_events[0].srv};
      in_offer   = 1'b1;
    end else if (!in_offer) begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predicted_picks.push_back(apply_event(in_tuser, in_tdata[SRV_W-1:0], in_tdata[SRV_W]));
      pending_events.delete(0);
      in_offer = 1'b0;
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_picks.size() == 0) begin
        $error("result transaction with no prediction pending");
        err_cnt++;
      end else begin
        want = predicted_picks[0];
        predicted_picks.delete(0);
        check_field("best_server", want.best, out_tdata[3:0]);
        check_field("best_connections", want.conns, out_tdata[19:4]);
        check_field("none_usable", want.none_usable, out_tdata[20]);
        check_field("over_half_failed", want.over_half, out_tdata[21]);
        check_field("failure_alarm", want.alarm, out_tdata[22]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb_least_connections_proxy_selector: done, errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < DEF_MAX_SERVERS; i++) begin
      conn_cnt[i] = '0;
      fail_run[i] = '0;
    end
    cfg_servers    = RST_SERVERS;
    cfg_fail_limit = RST_FAIL_LIMIT;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: success ignored on start, zero floor, alarm then past it
    add_event(CMD_START, 0, 1'b0);
    add_event(CMD_START, 0, 1'b1);
    add_event(CMD_START, 15, 1'b0);
    add_event(CMD_FINISH, 15, 1'b1);
    add_event(CMD_FINISH, 15, 1'b1);
    repeat (4) add_event(CMD_FINISH, 0, 1'b0);
    add_event(CMD_START, 1, 1'b1);
    add_event(CMD_START, 2, 1'b0);
    add_event(CMD_FINISH, 0, 1'b1);
    add_event(CMD_START, 0, 1'b0);
    drain_events();

    // small table: out-of-range index, then fail every entry
    reconfigure(4, 1);
    add_event(CMD_START, 9, 1'b0);
    add_event(CMD_FINISH, 9, 1'b0);
    for (int i = 0; i < 4; i++) add_event(CMD_FINISH, i, 1'b0);
    add_event(CMD_START, 3, 1'b1);
    drain_events();

    // empty table, then oversized count with a zero limit
    reconfigure(0, 3);
    add_event(CMD_START, 0, 1'b0);
    add_event(CMD_FINISH, 0, 1'b0);
    drain_events();
    reconfigure(31, 0);
    add_event(CMD_START, 15, 1'b0);
    add_event(CMD_FINISH, 5, 1'b0);
    drain_events();

    // run one failure counter into its ceiling
    steady = 1'b1;
    reconfigure(2, 255);
    for (int k = 0; k < 257; k++) add_event(CMD_FINISH, 0, 1'b0);
    add_event(CMD_START, 1, 1'b1);
    add_event(CMD_FINISH, 0, 1'b1);
    drain_events();
    steady = 1'b0;

    reconfigure(16, 3);
    queue_traffic(80, 30);
    hold_req = 1'b1;
    drain_events();

    reconfigure(1, 1);
    queue_traffic(40, 40);
    drain_events();

    // pause the sender mid-phase until all reports are back
    reconfigure(8, 2);
    queue_traffic(30, 35);
    drain_events();
    queue_traffic(30, 35);
    drain_events();

    steady = 1'b1;
    reconfigure(5, 255);
    queue_traffic(50, 50);
    drain_events();
    steady = 1'b0;

    reconfigure(12, 4);
    queue_traffic(60, 30);
    drain_events();

    reconfigure(3, 1);
    queue_traffic(30, 45);
    drain_events();

    if (err_cnt == 0) begin
      $display("tb_least_connections_proxy_selector: done, clean");
    end else begin
      $display("tb_least_connections_proxy_selector: done, errors");
    end
    $finish;
  end

endmodule
